// ===== hw/rtl/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared widths, constants and types for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;
    localparam int DUE_W  = 2;

    // UTF-16 surrogate tags, the top six bits of each unit of a pair
    localparam logic [5:0] SUR_HI_TAG = 6'b110110;
    localparam logic [5:0] SUR_LO_TAG = 6'b110111;

    // Lead byte prefixes
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    typedef logic [DUE_W-1:0] t_due;
    typedef logic [CP_W-1:0]  t_cp;

    // Result beat from the decode stage to the output stage
    typedef struct packed {
        logic emit;
        logic bad;
        t_cp  cp;
    } t_dec_beat;

endpackage

// ===== hw/rtl/u8sd_decode.sv =====
// ----------------------------------------------------------------------------
// u8sd_decode
// Input register and sequence tracker: gathers payload bits across bytes
// and presents a finished code point or an error beat.
// ----------------------------------------------------------------------------
module u8sd_decode
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_out_free,
    output t_dec_beat         o_dec
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_due              r_due;
    t_cp               r_bits;

    t_due              n_due;
    t_cp               n_bits;
    t_cp               shifted;
    t_due              due_dec;
    logic              advance;

    assign shifted = {r_bits[CP_W-7:0], r_in_byte[5:0]};
    assign due_dec = r_due - t_due'(1);

    always_comb begin
        o_dec  = '0;
        n_due  = r_due;
        n_bits = r_bits;
        if (r_due == '0) begin
            if (!r_in_byte[7]) begin
                o_dec.emit = 1'b1;
                o_dec.cp   = t_cp'(r_in_byte);
            end else if (r_in_byte[7:5] == LEAD2_TAG) begin
                n_bits = t_cp'(r_in_byte[4:0]);
                n_due  = t_due'(1);
            end else if (r_in_byte[7:4] == LEAD3_TAG) begin
                n_bits = t_cp'(r_in_byte[3:0]);
                n_due  = t_due'(2);
            end else if (r_in_byte[7:3] == LEAD4_TAG) begin
                n_bits = t_cp'(r_in_byte[2:0]);
                n_due  = t_due'(3);
            end else begin
                o_dec.emit = 1'b1;
                o_dec.bad  = 1'b1;
                n_bits     = '0;
            end
        end else if (r_in_byte[7:6] != CONT_TAG) begin
            // drop the byte, do not reuse it as a lead
            o_dec.emit = 1'b1;
            o_dec.bad  = 1'b1;
            n_bits     = '0;
            n_due      = '0;
        end else if (due_dec == '0) begin
            o_dec.emit = 1'b1;
            o_dec.cp   = shifted;
            n_bits     = '0;
            n_due      = '0;
        end else begin
            n_bits = shifted;
            n_due  = due_dec;
        end
        if (!r_in_valid) begin
            o_dec.emit = 1'b0;
        end
    end

    // hold the byte while a result beat cannot move on
    assign advance    = r_in_valid && (!o_dec.emit || i_out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_due      <= '0;
            r_bits     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_due  <= n_due;
                r_bits <= n_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && o_dec.emit |=> r_due == '0)
        else $error("state not idle after a result beat");

    a_silent_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !o_dec.emit |=> r_due != '0)
        else $error("byte consumed without result but tracker idle");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.emit && o_dec.bad |-> o_dec.cp == '0)
        else $error("error beat carries a code point");

endmodule

// ===== hw/rtl/u8sd_output.sv =====
// ----------------------------------------------------------------------------
// u8sd_output
// UTF-16 encoder and result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
module u8sd_output
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dec_beat         i_dec,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CP_W-1:0]   o_code_point,
    output logic              o_bad_sequence,
    output logic [UNIT_W-1:0] o_first_unit,
    output logic [UNIT_W-1:0] o_second_unit,
    output logic              o_two_units
);

    logic              r_out_valid;
    t_cp               r_code_point;
    logic              r_bad;
    logic [UNIT_W-1:0] r_first_unit;
    logic [UNIT_W-1:0] r_second_unit;
    logic              r_two_units;

    logic              n_pair;
    logic [3:0]        plane;
    logic [UNIT_W-1:0] n_first_unit;
    logic [UNIT_W-1:0] n_second_unit;
    logic              load;

    assign n_pair = i_dec.cp[CP_W-1:UNIT_W] != '0;
    // plane minus one, wrapping, kept to four bits
    assign plane  = 4'(i_dec.cp[CP_W-1:UNIT_W] - 5'd1);

    always_comb begin
        if (n_pair) begin
            n_first_unit  = {SUR_HI_TAG, plane, i_dec.cp[15:10]};
            n_second_unit = {SUR_LO_TAG, i_dec.cp[9:0]};
        end else begin
            n_first_unit  = i_dec.cp[UNIT_W-1:0];
            n_second_unit = '0;
        end
    end

    assign o_free = !r_out_valid || i_out_ready;
    assign load   = o_free && i_dec.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_free) begin
            r_out_valid <= i_dec.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code_point  <= i_dec.cp;
            r_bad         <= i_dec.bad;
            r_first_unit  <= n_first_unit;
            r_second_unit <= n_second_unit;
            r_two_units   <= n_pair;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_code_point   = r_code_point;
    assign o_bad_sequence = r_bad;
    assign o_first_unit   = r_first_unit;
    assign o_second_unit  = r_second_unit;
    assign o_two_units    = r_two_units;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("loaded beat not presented");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_two_units |-> r_code_point[CP_W-1:UNIT_W] != '0)
        else $error("surrogate pair for a BMP code point");

    a_bad_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bad |-> !r_two_units && r_first_unit == '0)
        else $error("error beat carries UTF-16 units");

endmodule

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// A byte accepted into the input register is decoded and then registered in the
// result register. Throughput: one byte per cycle while results move on; a stalled
// result holds one byte in the input register.
// Reset (i_rst_n low, synchronous): clears both valid flags and the decoder
// state, so decoding resumes at a lead byte.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to 21-bit code point and UTF-16 units, one byte per beat.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CP_W-1:0]   o_code_point,
    output logic              o_bad_sequence,
    output logic [UNIT_W-1:0] o_first_unit,
    output logic [UNIT_W-1:0] o_second_unit,
    output logic              o_two_units
);

    t_dec_beat dec;
    logic      out_free;

    u8sd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_out_free (out_free),
        .o_dec      (dec)
    );

    u8sd_output u_output (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dec          (dec),
        .o_free         (out_free),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_code_point   (o_code_point),
        .o_bad_sequence (o_bad_sequence),
        .o_first_unit   (o_first_unit),
        .o_second_unit  (o_second_unit),
        .o_two_units    (o_two_units)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_stream_decoder_unit. A driver feeds one byte
// per beat from a queue; each accepted byte runs through a decoder model
// that predicts the code point and UTF-16 units, and a monitor compares
// every result beat in order. Idle patterns vary by phase and include a
// long receiver stall.
// ----------------------------------------------------------------------------
module tb
    import u8sd_pkg::*;
;

    localparam int RANDOM_PER_PHASE = 510;
    localparam int LONG_HOLD        = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int TAIL_CYCLES      = 4;

    typedef struct packed {
        t_cp               cp;
        logic              bad;
        logic [UNIT_W-1:0] u0;
        logic [UNIT_W-1:0] u1;
        logic              pair;
    } t_char_out;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic [BYTE_W-1:0] i_in_byte      = '0;
    logic              i_out_ready    = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [CP_W-1:0]   o_code_point;
    logic              o_bad_sequence;
    logic [UNIT_W-1:0] o_first_unit;
    logic [UNIT_W-1:0] o_second_unit;
    logic              o_two_units;

    logic [BYTE_W-1:0] byte_q [$];
    t_char_out         char_q [$];

    // decoder model state
    t_cp  dec_bits = '0;
    t_due dec_due  = '0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic long_stall_req = 1'b0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int fail_count     = 0;
    int bytes_taken    = 0;
    int chars_checked  = 0;
    int bad_seen       = 0;
    int pairs_seen     = 0;

    logic [BYTE_W-1:0] directed_seq [0:24] = '{
        8'h00, 8'h7F,                   // ASCII extremes
        8'hC2, 8'h80,                   // smallest two-byte form
        8'hC0, 8'h80,                   // overlong, passes through
        8'hEF, 8'hBF, 8'hBF,            // 0xFFFF, last single unit
        8'hF0, 8'h90, 8'h80, 8'h80,     // 0x10000, first pair
        8'hF4, 8'h8F, 8'hBF, 8'hBF,     // 0x10FFFF
        8'hF7, 8'hBF, 8'hBF, 8'hBF,     // beyond Unicode, plane wraps
        8'h80,                          // stray continuation
        8'hF8,                          // invalid lead
        8'hC3, 8'h41                    // truncated, breaker is consumed
    };

    utf8_stream_decoder_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_code_point   (o_code_point),
        .o_bad_sequence (o_bad_sequence),
        .o_first_unit   (o_first_unit),
        .o_second_unit  (o_second_unit),
        .o_two_units    (o_two_units)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_char_out char_out(input t_cp cp, input logic bad);
        t_char_out r;
        logic [3:0] plane;
        r      = '0;
        r.cp   = cp;
        r.bad  = bad;
        plane  = 4'(cp[20:16] - 5'd1);
        if (cp[20:16] != '0) begin
            r.u0   = {SUR_HI_TAG, plane, cp[15:10]};
            r.u1   = {SUR_LO_TAG, cp[9:0]};
            r.pair = 1'b1;
        end else begin
            r.u0 = cp[15:0];
        end
        return r;
    endfunction

    // Advance the decoder by one byte; returns 1 when the byte yields a result.
    function automatic logic decode_step(input logic [BYTE_W-1:0] b, output t_char_out r);
        r = '0;
        if (dec_due == '0) begin
            if (!b[7]) begin
                r = char_out(t_cp'(b), 1'b0);
                return 1'b1;
            end
            if (b[7:5] == LEAD2_TAG) begin
                dec_bits = t_cp'(b[4:0]);
                dec_due  = 2'd1;
            end else if (b[7:4] == LEAD3_TAG) begin
                dec_bits = t_cp'(b[3:0]);
                dec_due  = 2'd2;
            end else if (b[7:3] == LEAD4_TAG) begin
                dec_bits = t_cp'(b[2:0]);
                dec_due  = 2'd3;
            end else begin
                dec_bits = '0;
                r = char_out('0, 1'b1);
                return 1'b1;
            end
            return 1'b0;
        end
        if (b[7:6] != CONT_TAG) begin
            dec_bits = '0;
            dec_due  = '0;
            r = char_out('0, 1'b1);
            return 1'b1;
        end
        dec_bits = {dec_bits[CP_W-7:0], b[5:0]};
        dec_due  = dec_due - 2'd1;
        if (dec_due == '0) begin
            r = char_out(dec_bits, 1'b0);
            dec_bits = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return {CONT_TAG, 6'($urandom)};
    endfunction

    function automatic logic [BYTE_W-1:0] lead_byte(input int len);
        case (len)
            2:       return {LEAD2_TAG, 5'($urandom)};
            3:       return {LEAD3_TAG, 4'($urandom)};
            4:       return {LEAD4_TAG, 3'($urandom)};
            default: return {1'b0, 7'($urandom)};
        endcase
    endfunction

    // Mostly well-formed characters with random payload, plus noise bytes
    // and sequences cut short by a non-continuation byte.
    task automatic queue_random(input int n);
        int sent;
        int kind;
        int len;
        int k;
        logic [BYTE_W-1:0] brk;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                len = $urandom_range(1, 4);
                byte_q.push_back(lead_byte(len));
                for (k = 1; k < len; k++) byte_q.push_back(cont_byte());
                sent += len;
            end else if (kind < 90) begin
                byte_q.push_back(8'($urandom));
                sent++;
            end else begin
                len = $urandom_range(2, 4);
                byte_q.push_back(lead_byte(len));
                k = $urandom_range(0, len - 2);
                sent += k + 2;
                repeat (k) byte_q.push_back(cont_byte());
                brk = 8'($urandom);
                while (brk[7:6] == CONT_TAG) brk = 8'($urandom);
                byte_q.push_back(brk);
            end
        end
    endtask

    // Hold the sender until every queued byte is taken and every result is back.
    task automatic wait_for_drain();
        while (byte_q.size() != 0 || i_in_valid || char_q.size() != 0)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_proc
        t_char_out want;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                if (decode_step(i_in_byte, want)) char_q.push_back(want);
            end
            if (!i_in_valid || o_in_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_byte  <= byte_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor_proc
        t_char_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (char_q.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = char_q.pop_front();
                chars_checked++;
                if (want.bad) bad_seen++;
                if (want.pair) pairs_seen++;
                if (o_code_point !== want.cp)
                    report_mismatch($sformatf("code_point %h, want %h",
                                              o_code_point, want.cp));
                if (o_bad_sequence !== want.bad)
                    report_mismatch($sformatf("bad_sequence %b, want %b",
                                              o_bad_sequence, want.bad));
                if (o_first_unit !== want.u0)
                    report_mismatch($sformatf("first_unit %h, want %h (cp %h)",
                                              o_first_unit, want.u0, want.cp));
                if (o_second_unit !== want.u1)
                    report_mismatch($sformatf("second_unit %h, want %h (cp %h)",
                                              o_second_unit, want.u1, want.cp));
                if (o_two_units !== want.pair)
                    report_mismatch($sformatf("two_units %b, want %b (cp %h)",
                                              o_two_units, want.pair, want.cp));
            end
        end
        if (long_stall_req) hold_left = LONG_HOLD;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_seq[i]) byte_q.push_back(directed_seq[i]);
        wait_for_drain();

        send_idle_pct = 21;
        recv_idle_pct = 72;
        queue_random(RANDOM_PER_PHASE);
        wait_for_drain();

        send_idle_pct = 72;
        recv_idle_pct = 21;
        queue_random(RANDOM_PER_PHASE);
        wait_for_drain();

        // back-to-back bytes against a long receiver stall
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        long_stall_req = 1'b1;
        queue_random(RANDOM_PER_PHASE);
        @(negedge i_clk);
        long_stall_req = 1'b0;
        wait_for_drain();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("tb: %0d bytes decoded into %0d results", bytes_taken, chars_checked);
        $display("tb: %0d bad sequences, %0d surrogate pairs, %0d mismatches",
                 bad_seen, pairs_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_decode.sv
hw/rtl/u8sd_output.sv
hw/rtl/utf8_stream_decoder_unit.sv
tb/sv/tb.sv
